@@ rtl/huffman_code_bit_packer_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the Huffman code bit packer
// Shared implication forms, clocked on clk and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_CODE_BIT_PACKER_TOP_MACROS_SVH
`define HUFFMAN_CODE_BIT_PACKER_TOP_MACROS_SVH

// same-cycle implication
`define HCBP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HCBP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/hcbp_pkg.sv @@
// ----------------------------------------------------------------------------
// hcbp_pkg
// Types and constants for the Huffman code bit packer.
// ----------------------------------------------------------------------------
`default_nettype none

package hcbp_pkg;

    // code length limits
    localparam int MAX_CODE_LEN = 32;
    localparam int CODE_W       = 32;
    localparam int LEN_W        = 6;
    localparam logic [LEN_W-1:0] LEN_LIMIT =
        LEN_W'((MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W);

    localparam int BYTE_W  = 8;
    localparam int FILL_W  = 4;
    localparam int TOTAL_W = 48;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
    localparam logic [FILL_W-1:0]  BYTE_BITS = FILL_W'(BYTE_W);

    // function codes
    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_ENCODE = 2'd1;
    localparam logic [1:0] FUNC_FINISH = 2'd2;

    typedef struct packed {
        logic [1:0]        func;
        logic [7:0]        symbol;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_len;
    } req_word_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic [FILL_W-1:0]  valid_bits;
        logic [TOTAL_W-1:0] total_bits;
        logic               is_last;
    } rsp_word_t;

    typedef struct packed {
        logic [CODE_W-1:0] word;
        logic [LEN_W-1:0]  len;
    } code_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_RUN,
        ST_FLUSH
    } pack_state_t;

endpackage

`default_nettype wire

@@ rtl/huffman_code_bit_packer_top.sv @@
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_top
// Code table plus MSB-first byte packer for a Huffman encoder back end.
//
// Request channel (req_valid / req_stall / req) carries load, encode and
// finish words. Response channel (rsp_valid / rsp_stall / rsp) carries one
// word per packed byte. A load, or an unused function code, leaves the
// packer idle. An encode is accepted, reads the synchronous table, then
// packs one chunk of code bits per cycle, a chunk being the bits that
// fit into the current byte box, except while a full box waits for the
// output register: at most five chunks for a 32-bit code, none for an
// empty code. A finish always returns one word. One item is worked on
// at a time; req_stall is high until it is done. A response word sits in
// an output register, so a new request is taken while the last word
// still waits. When rsp_stall holds that register and another byte is
// due, the packer waits in place. Reset clears the packer, the bit total
// and the channels; the code table is not cleared and must be loaded
// before a symbol is encoded.
// ----------------------------------------------------------------------------
`default_nettype none

`include "huffman_code_bit_packer_top_macros.svh"

module huffman_code_bit_packer_top (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire hcbp_pkg::req_word_t req,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output hcbp_pkg::rsp_word_t    rsp
);
    import hcbp_pkg::*;

    // code table and its registered read port
    code_entry_t code_mem [256];
    code_entry_t rd_reg;

    pack_state_t state_reg, state_next;

    logic [BYTE_W-1:0]  box_reg, box_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [LEN_W-1:0]   rem_reg, rem_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_word_t          rsp_reg, rsp_next;

    logic        req_accept;
    logic        tbl_we;
    logic        tbl_re;
    logic        out_free;
    logic        out_load;
    code_entry_t wr_entry;
    logic [LEN_W-1:0] len_clamp;

    // packing datapath signals
    logic              box_full;
    logic [FILL_W-1:0] base_fill;
    logic [BYTE_W-1:0] base_box;
    logic [FILL_W-1:0] room;
    logic [FILL_W-1:0] take;
    logic [LEN_W-1:0]  shamt;
    logic [CODE_W-1:0] shifted;
    logic [BYTE_W-1:0] chunk_mask;
    logic [BYTE_W-1:0] chunk;
    logic [2*BYTE_W-1:0] box_shift;
    logic [BYTE_W-1:0] packed_box;
    logic [TOTAL_W:0]  sum_byte;
    logic [TOTAL_W:0]  sum_fill;
    logic [TOTAL_W-1:0] total_plus_byte;
    logic [TOTAL_W-1:0] total_plus_fill;

    assign req_accept = req_valid && !req_stall;
    assign req_stall  = (state_reg != ST_IDLE);
    assign out_free   = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

    // load entry: clamp length, drop bits above it
    always_comb
    begin
        len_clamp     = (req.code_len > LEN_LIMIT) ? LEN_LIMIT : req.code_len;
        wr_entry.len  = len_clamp;
        wr_entry.word = req.code_bits &
                        CODE_W'(({1'b0, {CODE_W{1'b0}}} | (33'd1 << len_clamp)) - 33'd1);
    end

    assign tbl_we = req_accept && (req.func == FUNC_LOAD);
    assign tbl_re = req_accept && (req.func == FUNC_ENCODE);

    // table memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            code_mem[req.symbol] <= wr_entry;
        end
        if (tbl_re)
        begin
            rd_reg <= code_mem[req.symbol];
        end
    end

    // one chunk: the next code bits that fit into the box
    always_comb
    begin
        box_full   = (fill_reg == BYTE_BITS);
        base_fill  = box_full ? '0 : fill_reg;
        base_box   = box_full ? '0 : box_reg;
        room       = BYTE_BITS - base_fill;
        take       = ({2'b00, room} < rem_reg) ? room : rem_reg[FILL_W-1:0];
        shamt      = rem_reg - {2'b00, take};
        shifted    = rd_reg.word >> shamt;
        chunk_mask = BYTE_W'((9'd1 << take) - 9'd1);
        chunk      = shifted[BYTE_W-1:0] & chunk_mask;
        box_shift  = {{BYTE_W{1'b0}}, base_box} << take;
        packed_box = box_shift[BYTE_W-1:0] | chunk;
    end

    // saturating bit total
    always_comb
    begin
        sum_byte        = {1'b0, total_reg} + (TOTAL_W+1)'(BYTE_W);
        sum_fill        = {1'b0, total_reg} + (TOTAL_W+1)'(fill_reg);
        total_plus_byte = sum_byte[TOTAL_W] ? TOTAL_MAX : sum_byte[TOTAL_W-1:0];
        total_plus_fill = sum_fill[TOTAL_W] ? TOTAL_MAX : sum_fill[TOTAL_W-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_accept && (req.func == FUNC_ENCODE))
                begin
                    state_next = ST_FETCH;
                end
                else if (req_accept && (req.func == FUNC_FINISH))
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FETCH:
            begin
                state_next = (rd_reg.len != '0) ? ST_RUN : ST_IDLE;
            end
            ST_RUN:
            begin
                if (!box_full || out_free)
                begin
                    state_next = (rem_reg == {2'b00, take}) ? ST_IDLE : ST_RUN;
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and output control
    always_comb
    begin
        box_next   = box_reg;
        fill_next  = fill_reg;
        total_next = total_reg;
        rem_next   = rem_reg;
        out_load   = 1'b0;
        rsp_next   = rsp_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_FETCH:
            begin
                rem_next = rd_reg.len;
            end
            ST_RUN:
            begin
                if (!box_full || out_free)
                begin
                    // a full box leaves just before the next bit enters
                    if (box_full)
                    begin
                        out_load            = 1'b1;
                        rsp_next.out_byte   = box_reg;
                        rsp_next.valid_bits = BYTE_BITS;
                        rsp_next.total_bits = '0;
                        rsp_next.is_last    = (rem_reg <= LEN_W'(BYTE_W));
                        total_next          = total_plus_byte;
                    end
                    box_next  = packed_box;
                    fill_next = base_fill + take;
                    rem_next  = rem_reg - {2'b00, take};
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_load            = 1'b1;
                    rsp_next.out_byte   = box_reg;
                    rsp_next.valid_bits = fill_reg;
                    rsp_next.total_bits = total_plus_fill;
                    rsp_next.is_last    = 1'b1;
                    box_next            = '0;
                    fill_next           = '0;
                    total_next          = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // output register handshake
    always_comb
    begin
        if (out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg && rsp_stall;
        end
    end

    // control and packer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            box_reg       <= '0;
            fill_reg      <= '0;
            total_reg     <= '0;
            rem_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            box_reg       <= box_next;
            fill_reg      <= fill_next;
            total_reg     <= total_next;
            rem_reg       <= rem_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // response payload, no reset needed
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    // checks
    `HCBP_ASSERT_IMP(a_no_overwrite, out_load, out_free, "response overwritten while held")
    `HCBP_ASSERT_IMP(a_fill_range, 1'b1, fill_reg <= BYTE_BITS, "box fill above a byte")
    `HCBP_ASSERT_IMP(a_total_bytes, 1'b1, (total_reg[2:0] == 3'd0) || (total_reg == TOTAL_MAX), "bit total not whole bytes")
    `HCBP_ASSERT_NXT(a_encode_fetch, req_accept && (req.func == FUNC_ENCODE), state_reg == ST_FETCH, "encode did not read the table")

endmodule

`default_nettype wire

@@ dv/hcbp_pack_checker.sv @@
// ----------------------------------------------------------------------------
// hcbp_pack_checker
// Watches both channels of the Huffman code bit packer. It keeps its own
// code table and byte box, works out the packed bytes owed for every
// accepted request word, and compares each accepted response word with
// the oldest one owed.
// ----------------------------------------------------------------------------
module hcbp_pack_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_stall,
    input  hcbp_pkg::req_word_t req,
    input  logic                rsp_valid,
    input  logic                rsp_stall,
    input  hcbp_pkg::rsp_word_t rsp,
    output int                  mismatches,
    output int                  bytes_owed
);
    import hcbp_pkg::*;

    // shadow of the code table and the packer
    logic [CODE_W-1:0]  tbl_word [256];
    logic [LEN_W-1:0]   tbl_len  [256];
    logic [BYTE_W-1:0]  box       = '0;
    logic [FILL_W-1:0]  box_bits  = '0;
    logic [TOTAL_W-1:0] bits_sent = '0;

    rsp_word_t due_bytes [$];
    int        n_bad  = 0;
    int        n_owed = 0;

    assign mismatches = n_bad;
    assign bytes_owed = n_owed;

    // add with clamp at the top of the 48-bit range
    function automatic logic [TOTAL_W-1:0] clamp_add(logic [TOTAL_W-1:0] a,
                                                     int unsigned b);
        logic [TOTAL_W:0] s;
        s = {1'b0, a} + (TOTAL_W + 1)'(b);
        return s[TOTAL_W] ? TOTAL_MAX : s[TOTAL_W-1:0];
    endfunction

    // append one owed word at the tail of the queue
    task automatic owe_word(input rsp_word_t w);
        due_bytes = {due_bytes, w};
    endtask

    // apply one request word and queue the bytes it owes
    task automatic pack_request(input req_word_t w);
        logic [LEN_W-1:0]  n;
        logic [CODE_W-1:0] cw;
        rsp_word_t         held;
        int                n_out;
        n_out = 0;
        held  = '0;
        case (w.func)
            FUNC_LOAD: begin
                n  = (w.code_len > LEN_LIMIT) ? LEN_LIMIT : w.code_len;
                cw = w.code_bits;
                if (n < CODE_W)
                    cw = cw & ((CODE_W'(1) << n) - CODE_W'(1));
                tbl_word[w.symbol] = cw;
                tbl_len[w.symbol]  = n;
            end
            FUNC_ENCODE: begin
                for (int i = int'(tbl_len[w.symbol]); i > 0; i--) begin
                    // full box leaves only when the next bit arrives
                    if (box_bits >= BYTE_BITS) begin
                        if (n_out > 0)
                            owe_word(held);
                        held            = '0;
                        held.out_byte   = box;
                        held.valid_bits = BYTE_BITS;
                        n_out++;
                        bits_sent = clamp_add(bits_sent, BYTE_W);
                        box       = '0;
                        box_bits  = '0;
                    end
                    box = {box[BYTE_W-2:0], tbl_word[w.symbol][i-1]};
                    box_bits++;
                end
                if (n_out > 0) begin
                    held.is_last = 1'b1;
                    owe_word(held);
                end
            end
            FUNC_FINISH: begin
                held.out_byte   = box;
                held.valid_bits = box_bits;
                held.total_bits = clamp_add(bits_sent, box_bits);
                held.is_last    = 1'b1;
                owe_word(held);
                box       = '0;
                box_bits  = '0;
                bits_sent = '0;
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n) begin
        rsp_word_t want;
        if (!rst_n) begin
            box       = '0;
            box_bits  = '0;
            bits_sent = '0;
            due_bytes.delete();
            n_owed = 0;
        end else begin
            // response side first: a word leaving now is never from this request
            if (rsp_valid && !rsp_stall) begin
                if (due_bytes.size() == 0) begin
                    $error("response word with none owed: out_byte %0h valid_bits %0d",
                           rsp.out_byte, rsp.valid_bits);
                    n_bad++;
                end else begin
                    want = due_bytes.pop_front();
                    if (rsp.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %0h, got %0h",
                               want.out_byte, rsp.out_byte);
                        n_bad++;
                    end
                    if (rsp.valid_bits !== want.valid_bits) begin
                        $error("valid_bits: expected %0d, got %0d",
                               want.valid_bits, rsp.valid_bits);
                        n_bad++;
                    end
                    if (rsp.total_bits !== want.total_bits) begin
                        $error("total_bits: expected %0d, got %0d",
                               want.total_bits, rsp.total_bits);
                        n_bad++;
                    end
                    if (rsp.is_last !== want.is_last) begin
                        $error("is_last: expected %0b, got %0b",
                               want.is_last, rsp.is_last);
                        n_bad++;
                    end
                end
            end
            if (req_valid && !req_stall)
                pack_request(req);
            n_owed = due_bytes.size();
        end
    end

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Top of the Huffman code bit packer bench. Loads code words, encodes
// symbols and flushes the packer: a directed pass over the corner cases,
// a back-pressure pass, then random traffic with random gaps on both
// channels. Checking is done by hcbp_pack_checker.
// ----------------------------------------------------------------------------
module tb;
    import hcbp_pkg::*;

    localparam logic [1:0] FUNC_SPARE   = 2'd3;
    localparam int         LONG_HOLD    = 150;
    localparam int         RANDOM_ITEMS = 105;
    localparam int         SETTLE       = 12;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_word_t req;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_word_t rsp;
    int        mismatches;
    int        bytes_owed;

    bit         loaded [256];
    logic [7:0] live_syms [$];
    bit         hold_request = 1'b0;
    bit         tx_quiet     = 1'b0;

    huffman_code_bit_packer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    hcbp_pack_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .mismatches (mismatches),
        .bytes_owed (bytes_owed)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // gap length: mostly none or short, a few long
    function automatic int unsigned idle_len(bit quiet);
        int unsigned r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // offer one word, hold it until taken, then maybe idle
    task automatic offer(input req_word_t w);
        int unsigned gap;
        req       <= w;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
        @(negedge clk);
        gap = idle_len(tx_quiet);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic load_code(input logic [7:0] sym, input logic [CODE_W-1:0] bits,
                             input logic [LEN_W-1:0] len);
        req_word_t w;
        w.func      = FUNC_LOAD;
        w.symbol    = sym;
        w.code_bits = bits;
        w.code_len  = len;
        if (!loaded[sym]) begin
            loaded[sym] = 1'b1;
            live_syms   = {live_syms, sym};
        end
        offer(w);
    endtask

    task automatic encode_sym(input logic [7:0] sym);
        req_word_t w;
        w           = '0;
        w.func      = FUNC_ENCODE;
        w.symbol    = sym;
        w.code_bits = $urandom();
        w.code_len  = LEN_W'($urandom_range(0, 63));
        offer(w);
    endtask

    task automatic finish_stream();
        req_word_t w;
        w.func      = FUNC_FINISH;
        w.symbol    = $urandom_range(0, 255);
        w.code_bits = $urandom();
        w.code_len  = LEN_W'($urandom_range(0, 63));
        offer(w);
    endtask

    task automatic random_load();
        int unsigned r;
        logic [LEN_W-1:0] len;
        r = $urandom_range(0, 99);
        if (r < 5)
            len = '0;
        else if (r < 70)
            len = LEN_W'($urandom_range(1, 10));
        else if (r < 92)
            len = LEN_W'($urandom_range(11, 32));
        else
            len = LEN_W'($urandom_range(33, 63));
        load_code($urandom_range(0, 255), $urandom(), len);
    endtask

    // sender pauses until every owed byte is back, then lets the block settle
    task automatic drain_results();
        req_valid <= 1'b0;
        while (bytes_owed != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // receiver: random stalls, quiet stretches, and the long hold on request
    initial begin
        int unsigned stall_left;
        int unsigned span;
        bit          rx_quiet;
        stall_left = 0;
        span       = 0;
        rx_quiet   = 1'b0;
        rsp_stall  = 1'b0;
        forever begin
            @(negedge clk);
            if (span == 0) begin
                span     = $urandom_range(30, 80);
                rx_quiet = ($urandom_range(0, 3) == 0);
            end
            span--;
            if (hold_request) begin
                hold_request <= 1'b0;
                stall_left = LONG_HOLD;
            end else if (stall_left == 0 && $urandom_range(0, 2) == 0) begin
                stall_left = idle_len(rx_quiet);
            end
            if (stall_left > 0) begin
                rsp_stall <= 1'b1;
                stall_left--;
            end else begin
                rsp_stall <= 1'b0;
            end
        end
    end

    // stimulus
    initial begin
        req_word_t   w;
        int unsigned r;
        int          k;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: table corners, empty / full / partial box on finish
        load_code(8'h00, 32'hFFFF_FFFF, 6'd63);   // length clamps to 32
        load_code(8'hFF, 32'hFFFF_FFFE, 6'd1);    // upper bits dropped
        load_code(8'h55, 32'hA5A5_A5A5, 6'd32);
        load_code(8'hAA, 32'hFFFF_FF00, 6'd0);    // empty code
        load_code(8'h3C, 32'h1234_56F3, 6'd8);
        finish_stream();                          // nothing in the box
        encode_sym(8'h3C);                        // box exactly full, no word yet
        finish_stream();                          // full box flushed
        encode_sym(8'hAA);                        // empty code, no word
        encode_sym(8'h00);
        encode_sym(8'h55);                        // four words: one byte of 8'h00, three of 8'h55
        encode_sym(8'hFF);
        finish_stream();                          // partial box
        w.func      = FUNC_SPARE;
        w.symbol    = 8'hFF;
        w.code_bits = 32'hFFFF_FFFF;
        w.code_len  = 6'd63;
        offer(w);                                 // unused code, ignored
        load_code(8'h55, 32'h8000_0001, 6'd33);
        encode_sym(8'h55);
        encode_sym(8'hFF);
        encode_sym(8'h55);
        finish_stream();
        drain_results();

        // back pressure: long receiver hold while the sender keeps pushing
        hold_request <= 1'b1;
        tx_quiet = 1'b1;
        for (k = 0; k < 16; k++)
            encode_sym(k[0] ? 8'h55 : 8'h3C);
        finish_stream();
        tx_quiet = 1'b0;
        drain_results();

        // random traffic: a populated table, then mostly encodes
        for (k = 0; k < 24; k++)
            random_load();
        k = 0;
        while (k < RANDOM_ITEMS) begin
            if (k % 20 == 0)
                tx_quiet = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 4) begin
                w.func      = FUNC_SPARE;
                w.symbol    = $urandom_range(0, 255);
                w.code_bits = $urandom();
                w.code_len  = LEN_W'($urandom_range(0, 63));
                offer(w);
            end else begin
                if (r < 12)
                    random_load();
                else if (r < 22)
                    finish_stream();
                else
                    encode_sym(live_syms[$urandom_range(0, live_syms.size() - 1)]);
                k++;
            end
        end
        finish_stream();
        drain_results();

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // run limit
    initial begin
        #800000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
